### design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and codes for the fixed-point ALU
// Operation codes, status codes and the side payload that rides the pipe.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // Everything but the divider's quotient and remainder.
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  status;
    logic        neg;
    logic        dz;
    logic [63:0] prod;
    logic [31:0] db;
  } side_t;

endpackage
`default_nettype wire

### design/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: signed fixed-point ALU with a chain of division cells
// Stages: decode, one divider cell per quotient bit, result.
// Throughput: one word per cycle while the output is not stalled; every operation runs through the same cell chain.
// A stalled result holds the whole pipe; req_stall follows rsp_stall while a word waits.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_stall,
  input  wire  [3:0]        req_type,
  input  wire  signed [31:0] operand_a,
  input  wire  signed [31:0] operand_b,
  output logic              rsp_valid,
  input  wire               rsp_stall,
  output logic signed [31:0] result_value,
  output logic              compare_true,
  output logic [1:0]        status
);
  import fpa_pkg::*;

  localparam int QW = 32 + FRACTION_BITS;

  logic            en;
  side_t           side [0:QW];
  logic [QW-1:0]   quo  [0:QW];
  logic [31:0]     rem  [0:QW];

  // advance unless a finished word is held at the output
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  fpa_front #(.FB(FRACTION_BITS), .QW(QW)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(req_valid),
    .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
    .side(side[0]), .quo(quo[0]), .rem(rem[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    fpa_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .side_in(side[i]), .quo_in(quo[i]), .rem_in(rem[i]),
      .side_out(side[i+1]), .quo_out(quo[i+1]), .rem_out(rem[i+1])
    );
  end

  fpa_back #(.FB(FRACTION_BITS), .QW(QW)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .side(side[QW]), .quo(quo[QW]), .rem(rem[QW]),
    .out_valid(rsp_valid), .value(result_value),
    .cmp(compare_true), .status(status)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_DZ |-> result_value == 32'sd0 && !compare_true)
    else $error("division by zero word carries data");
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && compare_true |-> result_value == 32'sd0 && status == ST_OK)
    else $error("comparison word carries value or status");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule
`default_nettype wire

### design/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: operand decode stage
// Computes the simple operations, the full product and the divider inputs.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front #(
  parameter int FB = 8,
  parameter int QW = 40
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_valid,
  input  wire  [3:0]        req_type,
  input  wire  signed [31:0] operand_a,
  input  wire  signed [31:0] operand_b,
  output fpa_pkg::side_t    side,
  output logic [QW-1:0]     quo,
  output logic [31:0]       rem
);
  import fpa_pkg::*;

  side_t              s_next;
  logic [32:0]        sum;
  logic [32:0]        dif;
  logic [32:0]        incv;
  logic [32:0]        decv;
  logic signed [QW-1:0] sh;
  logic [31:0]        amag;
  logic [31:0]        bmag;

  always_comb begin
    sum  = {operand_a[31], operand_a} + {operand_b[31], operand_b};
    dif  = {operand_a[31], operand_a} - {operand_b[31], operand_b};
    incv = {operand_a[31], operand_a} + 33'd1;
    decv = {operand_a[31], operand_a} - 33'd1;
    sh   = QW'(operand_a) <<< FB;
    amag = operand_a[31] ? 32'(-operand_a) : operand_a;
    bmag = operand_b[31] ? 32'(-operand_b) : operand_b;

    s_next.valid  = in_valid;
    s_next.op     = op_t'(req_type);
    s_next.value  = '0;
    s_next.cmp    = 1'b0;
    s_next.status = ST_OK;
    s_next.neg    = operand_a[31] ^ operand_b[31];
    s_next.dz     = (operand_b == 32'sd0);
    s_next.prod   = 64'(operand_a) * 64'(operand_b);
    s_next.db     = bmag;
    case (op_t'(req_type))
      OP_ADD: begin
        s_next.value  = sum[31:0];
        s_next.status = (sum[32] != sum[31]) ? ST_OVF : ST_OK;
      end
      OP_SUB: begin
        s_next.value  = dif[31:0];
        s_next.status = (dif[32] != dif[31]) ? ST_OVF : ST_OK;
      end
      OP_INC: begin
        s_next.value  = incv[31:0];
        s_next.status = (incv[32] != incv[31]) ? ST_OVF : ST_OK;
      end
      OP_DEC: begin
        s_next.value  = decv[31:0];
        s_next.status = (decv[32] != decv[31]) ? ST_OVF : ST_OK;
      end
      OP_GT: s_next.cmp = operand_a >  operand_b;
      OP_LT: s_next.cmp = operand_a <  operand_b;
      OP_GE: s_next.cmp = operand_a >= operand_b;
      OP_LE: s_next.cmp = operand_a <= operand_b;
      OP_EQ: s_next.cmp = operand_a == operand_b;
      OP_NE: s_next.cmp = operand_a != operand_b;
      OP_MIN: s_next.value = (operand_a < operand_b) ? operand_a : operand_b;
      OP_MAX: s_next.value = (operand_a > operand_b) ? operand_a : operand_b;
      OP_FROM_INT: begin
        s_next.value  = sh[31:0];
        s_next.status = (sh[QW-1:31] == {(QW-31){sh[31]}}) ? ST_OK : ST_OVF;
      end
      OP_TO_INT: s_next.value = 32'(operand_a >>> FB);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= s_next.valid;
    end
    if (en) begin
      side.op     <= s_next.op;
      side.value  <= s_next.value;
      side.cmp    <= s_next.cmp;
      side.status <= s_next.status;
      side.neg    <= s_next.neg;
      side.dz     <= s_next.dz;
      side.prod   <= s_next.prod;
      side.db     <= s_next.db;
      quo         <= QW'(amag) << FB;
      rem         <= '0;
    end
  end

endmodule
`default_nettype wire

### design/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell: one restoring-division cell
// Develops one quotient bit and hands the word on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_cell #(
  parameter int QW = 40
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                en,
  input  fpa_pkg::side_t     side_in,
  input  wire  [QW-1:0]      quo_in,
  input  wire  [31:0]        rem_in,
  output fpa_pkg::side_t     side_out,
  output logic [QW-1:0]      quo_out,
  output logic [31:0]        rem_out
);
  import fpa_pkg::*;

  logic [32:0] t;
  logic [32:0] d;
  logic        ge;

  always_comb begin
    t  = {rem_in, quo_in[QW-1]};
    d  = t - {1'b0, side_in.db};
    ge = !d[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side_in.valid;
    end
    if (en) begin
      side_out.op     <= side_in.op;
      side_out.value  <= side_in.value;
      side_out.cmp    <= side_in.cmp;
      side_out.status <= side_in.status;
      side_out.neg    <= side_in.neg;
      side_out.dz     <= side_in.dz;
      side_out.prod   <= side_in.prod;
      side_out.db     <= side_in.db;
      rem_out         <= ge ? d[31:0] : t[31:0];
      quo_out         <= {quo_in[QW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### design/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: result stage
// Rounds the product and the quotient, wraps to 32 bits, registers the word.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_back #(
  parameter int FB = 8,
  parameter int QW = 40
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  fpa_pkg::side_t    side,
  input  wire  [QW-1:0]     quo,
  input  wire  [31:0]       rem,
  output logic              out_valid,
  output logic [31:0]       value,
  output logic              cmp,
  output logic [1:0]        status
);
  import fpa_pkg::*;

  localparam logic [63:0] HALF = (FB == 0) ? 64'd0 : (64'd1 << ((FB == 0) ? 0 : FB - 1));

  logic        pneg;
  logic [63:0] pmag;
  logic [63:0] mmag;
  logic [QW:0] qmag;
  logic        movf;
  logic        qovf;
  logic [31:0] v_next;
  logic [1:0]  s_next;

  always_comb begin
    pneg = side.prod[63];
    pmag = pneg ? -side.prod : side.prod;
    mmag = (pmag + HALF) >> FB;
    movf = pneg ? (mmag > 64'h8000_0000) : (mmag > 64'h7FFF_FFFF);
    // round half away from zero: bump when twice the remainder reaches divisor
    qmag = {1'b0, quo} + (QW+1)'({rem, 1'b0} >= {1'b0, side.db});
    qovf = side.neg ? (qmag > (QW+1)'(33'h0_8000_0000))
                    : (qmag > (QW+1)'(33'h0_7FFF_FFFF));
    v_next = side.value;
    s_next = side.status;
    case (side.op)
      OP_MUL: begin
        v_next = pneg ? -mmag[31:0] : mmag[31:0];
        s_next = movf ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (side.dz) begin
          v_next = '0;
          s_next = ST_DZ;
        end else begin
          v_next = side.neg ? -qmag[31:0] : qmag[31:0];
          s_next = qovf ? ST_OVF : ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= side.valid;
    end
    if (en) begin
      value  <= v_next;
      cmp    <= side.cmp;
      status <= s_next;
    end
  end

endmodule
`default_nettype wire

### tb/tb_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_alu: self-checking bench for the signed fixed-point ALU
// Drives request words under several idle and stall mixes, predicts each
// result with exact wide integer arithmetic and checks every response word.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_fixed_point_alu;
  import fpa_pkg::*;

  localparam int FB = 8;
  localparam int LAT = 34 + FB;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic [1:0]         status;
  } alu_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [3:0] req_type = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic signed [31:0] result_value;
  logic compare_true;
  logic [1:0] status;

  alu_out_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  fixed_point_alu #(.FRACTION_BITS(FB)) uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .operand_a(operand_a), .operand_b(operand_b),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .result_value(result_value), .compare_true(compare_true), .status(status)
  );

  always #6 clk = ~clk;

  function automatic logic [1:0] wrap_status(longint s);
    return (s < -64'sd2147483648 || s > 64'sd2147483647) ? ST_OVF : ST_OK;
  endfunction

  function automatic alu_out_t alu_predict(op_t op, logic signed [31:0] a_in,
                                           logic signed [31:0] b_in);
    alu_out_t r;
    longint a, b, s, one;
    logic [63:0] mag, na, db, q, rm;
    logic neg;
    a = a_in;
    b = b_in;
    one = longint'(1) << FB;
    r = '0;
    s = 0;
    case (op)
      OP_ADD: s = a + b;
      OP_SUB: s = a - b;
      OP_INC: s = a + 1;
      OP_DEC: s = a - 1;
      OP_FROM_INT: s = a * one;
      OP_MUL: begin
        s = a * b;
        neg = s < 0;
        mag = neg ? -s : s;
        if (FB > 0) mag = (mag + (64'd1 << (FB - 1))) >> FB;
        s = neg ? -longint'(mag) : longint'(mag);
      end
      OP_DIV: begin
        if (b != 0) begin
          neg = (a < 0) != (b < 0);
          na = (a < 0 ? -a : a) << FB;
          db = b < 0 ? -b : b;
          q = na / db;
          rm = na % db;
          if (2 * rm >= db) q = q + 1;
          s = neg ? -longint'(q) : longint'(q);
        end
      end
      default: ;
    endcase
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_INC, OP_DEC, OP_FROM_INT: begin
        r.value = s[31:0];
        r.status = wrap_status(s);
      end
      OP_DIV: begin
        if (b == 0) r.status = ST_DZ;
        else begin
          r.value = s[31:0];
          r.status = wrap_status(s);
        end
      end
      OP_GT: r.cmp = a > b;
      OP_LT: r.cmp = a < b;
      OP_GE: r.cmp = a >= b;
      OP_LE: r.cmp = a <= b;
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.value = a < b ? a_in : b_in;
      OP_MAX: r.value = a > b ? a_in : b_in;
      OP_TO_INT: r.value = a_in >>> FB;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // Send one request word; hold it until accepted. Valid stays up for the next word.
  task automatic send_word(op_t op, logic [31:0] a, logic [31:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_q.push_back(alu_predict(op, a, b));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", result_value, 0);
      end else begin
        e = expected_q.pop_front();
        if (result_value !== e.value) report_mismatch("result_value", result_value, e.value);
        if (compare_true !== e.cmp) report_mismatch("compare_true", compare_true, e.cmp);
        if (status !== e.status) report_mismatch("status", status, e.status);
      end
    end
  end

  // Watchdog: count cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(2047) - 1024;
      3: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait until every expected word has come back.
  task automatic drain();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] corners[6];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'h80};
    for (int o = 0; o < 16; o++) send_word(op_t'(o), 32'h0000_0380, 32'hffff_fe80);
    send_word(OP_DIV, 32'h0000_1234, 32'h0);
    send_word(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
    send_word(OP_MUL, 32'h0000_0180, 32'h0000_0001);
    send_word(OP_MUL, 32'hffff_fe80, 32'h0000_0001);
    send_word(OP_DIV, 32'h0000_0001, 32'h0000_0200);
    send_word(OP_MIN, 32'h0000_0042, 32'h0000_0042);
    send_word(OP_TO_INT, 32'hffff_ffff, 32'h0);
    for (int i = 0; i < 6; i++) send_word(OP_MUL, corners[i], corners[5 - i]);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++)
      send_word(op_t'($urandom_range(15)), rand_operand(), rand_operand());
    drain();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // Hold the receiver off long enough that the pipe fills and backs up.
  task automatic test_backpressure();
    hold_cycles = 3 * LAT;
    for (int i = 0; i < 120; i++)
      send_word(op_t'($urandom_range(15)), rand_operand(), rand_operand());
    drain();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phase(450, 0, 0);
    test_random_phase(450, 50, 0);
    test_random_phase(450, 0, 50);
    test_random_phase(450, 12, 12);
    test_backpressure();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
